@@ hdl/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared constants and result codes for the crossing-number polygon test.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Default coordinate width of the vertex and query ports.
  localparam int unsigned CoordBitsDef = 16;

  // Width of the location code on the result channel.
  localparam int unsigned LocBits = 2;

  // Location of the query point relative to the closed polygon.
  typedef enum logic [LocBits-1:0] {
    LOC_OUTSIDE  = 2'd0,
    LOC_BOUNDARY = 2'd1,
    LOC_INSIDE   = 2'd2
  } loc_e;

endpackage

@@ hdl/point_in_polygon.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon tester
// Streams polygon vertices and reports whether the query point lies outside,
// on the boundary of, or inside the polygon, by crossing-number parity.
// ----------------------------------------------------------------------------
// Result path: the vertex marked last passes the input register, the product
// register and the result register before its result appears on out_valid_o.
// Throughput: one vertex per cycle while in_stall_o is low, set by the three-stage pipeline with
// one register slot per stage; bubbles are squeezed out under stall.
// Reset: rst_ni clears all valid bits and the parity and boundary flags, and
// arms the block so that the next vertex transfer starts a new polygon.
module point_in_polygon #(
  parameter int unsigned COORD_BITS = pip_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Vertex stream.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         last_vertex_i,
  // Result stream, one transfer per polygon.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pip_pkg::loc_e                location_o
);
  import pip_pkg::*;

  // A translated coordinate needs one bit more than the input, a product twice
  // that, and the sum or difference of two products one bit more again.
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned CW = PW + 1;

  // Signed zeros of the translated and summed widths, so that every sign test
  // below is a signed comparison.
  localparam logic signed [DW-1:0] DZero = '0;
  localparam logic signed [CW-1:0] CZero = '0;

  // --------------------------------------------------------------------------
  // Polygon context. The query point and the first vertex are latched on the
  // first vertex of each polygon; the previous vertex follows every transfer.
  // These are consumed only after await_first_q has been cleared by the first
  // vertex, so they need no reset.
  // --------------------------------------------------------------------------
  logic                         await_first_q;
  logic signed [COORD_BITS-1:0] qx_q, qy_q, fx_q, fy_q, px_q, py_q;

  logic                         in_xfer;
  logic signed [COORD_BITS-1:0] qx, qy, fx, fy;

  assign in_xfer = in_valid_i && !in_stall_o;

  // On the first vertex the query point comes straight from the ports and the
  // closing vertex is the current one.
  assign qx = await_first_q ? query_x_i  : qx_q;
  assign qy = await_first_q ? query_y_i  : qy_q;
  assign fx = await_first_q ? vertex_x_i : fx_q;
  assign fy = await_first_q ? vertex_y_i : fy_q;

  // Translate the three points of interest by the query point. Edge one runs
  // from the previous vertex (a) to the current one (b); edge two, the
  // closing edge, runs from the current vertex (b) to the first one (c).
  logic signed [DW-1:0] ax_d, ay_d, bx_d, by_d, cx_d, cy_d;

  assign ax_d = $signed({px_q[COORD_BITS-1], px_q}) - $signed({qx[COORD_BITS-1], qx});
  assign ay_d = $signed({py_q[COORD_BITS-1], py_q}) - $signed({qy[COORD_BITS-1], qy});
  assign bx_d = $signed({vertex_x_i[COORD_BITS-1], vertex_x_i})
              - $signed({qx[COORD_BITS-1], qx});
  assign by_d = $signed({vertex_y_i[COORD_BITS-1], vertex_y_i})
              - $signed({qy[COORD_BITS-1], qy});
  assign cx_d = $signed({fx[COORD_BITS-1], fx}) - $signed({qx[COORD_BITS-1], qx});
  assign cy_d = $signed({fy[COORD_BITS-1], fy}) - $signed({qy[COORD_BITS-1], qy});

  // --------------------------------------------------------------------------
  // Pipeline flow control. Each stage holds one item and moves on whenever
  // the stage after it is empty or emptying. An item that is not the last
  // vertex leaves stage two without touching the result register, so it
  // never waits for the output side.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, ov_q;
  logic first1_q, last1_q, first2_q, last2_q;
  logic out_free, s2_retire, s2_free, s1_move;

  assign out_free  = !ov_q || !out_stall_i;
  assign s2_retire = v2_q && (!last2_q || out_free);
  assign s2_free   = !v2_q || s2_retire;
  assign s1_move   = v1_q && s2_free;
  assign in_stall_o = v1_q && !s2_free;

  // Stage one: translated coordinates.
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

  // Stage two: the eight products and the vertical straddle tests. For each
  // edge, "up" means the start lies on or below the ray and the end above it,
  // "down" the reverse. An edge crosses the ray to the right of the point when
  // it goes up with a positive cross product or down with a negative one,
  // which matches ordering the ends by y before the test.
  logic signed [PW-1:0] p1_axby_d, p1_aybx_d, p1_axbx_d, p1_ayby_d;
  logic signed [PW-1:0] p2_bxcy_d, p2_bycx_d, p2_bxcx_d, p2_bycy_d;
  logic signed [PW-1:0] p1_axby_q, p1_aybx_q, p1_axbx_q, p1_ayby_q;
  logic signed [PW-1:0] p2_bxcy_q, p2_bycx_q, p2_bxcx_q, p2_bycy_q;
  logic up1_q, dn1_q, up2_q, dn2_q;

  assign p1_axby_d = ax_q * by_q;
  assign p1_aybx_d = ay_q * bx_q;
  assign p1_axbx_d = ax_q * bx_q;
  assign p1_ayby_d = ay_q * by_q;
  assign p2_bxcy_d = bx_q * cy_q;
  assign p2_bycx_d = by_q * cx_q;
  assign p2_bxcx_d = bx_q * cx_q;
  assign p2_bycy_d = by_q * cy_q;

  // Stage three: cross and dot products, edge verdicts and the running flags.
  // The boundary test is exact: the point lies on a segment when the cross
  // product is zero and the dot product of the translated ends is not
  // positive. A boundary edge never toggles the parity.
  logic signed [CW-1:0] cr1, dt1, cr2, dt2;
  logic on1, on2, tog1, tog2;
  logic parity_q, edge_q;
  logic par_base, edge_base, parity_d, edge_d;
  loc_e loc_d, loc_q;

  assign cr1 = CW'(p1_axby_q) - CW'(p1_aybx_q);
  assign dt1 = CW'(p1_axbx_q) + CW'(p1_ayby_q);
  assign cr2 = CW'(p2_bxcy_q) - CW'(p2_bycx_q);
  assign dt2 = CW'(p2_bxcx_q) + CW'(p2_bycy_q);

  // Edge one does not exist on the first vertex of a polygon; edge two only
  // exists on the last vertex.
  assign on1  = !first2_q && (cr1 == '0) && (dt1 <= CZero);
  assign on2  = last2_q && (cr2 == '0) && (dt2 <= CZero);
  assign tog1 = !first2_q && !on1
              && ((up1_q && (cr1 > CZero)) || (dn1_q && (cr1 < CZero)));
  assign tog2 = last2_q && !on2
              && ((up2_q && (cr2 > CZero)) || (dn2_q && (cr2 < CZero)));

  // The first vertex starts the flags afresh.
  assign par_base  = first2_q ? 1'b0 : parity_q;
  assign edge_base = first2_q ? 1'b0 : edge_q;
  assign parity_d  = par_base ^ tog1 ^ tog2;
  assign edge_d    = edge_base || on1 || on2;

  always_comb begin
    if (edge_d) begin
      loc_d = LOC_BOUNDARY;
    end else if (parity_d) begin
      loc_d = LOC_INSIDE;
    end else begin
      loc_d = LOC_OUTSIDE;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_first_q <= 1'b1;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      ov_q          <= 1'b0;
      parity_q      <= 1'b0;
      edge_q        <= 1'b0;
    end else begin
      if (in_xfer) begin
        await_first_q <= last_vertex_i;
      end
      if (in_xfer) begin
        v1_q <= 1'b1;
      end else if (s1_move) begin
        v1_q <= 1'b0;
      end
      if (s1_move) begin
        v2_q <= 1'b1;
      end else if (s2_retire) begin
        v2_q <= 1'b0;
      end
      if (s2_retire && last2_q) begin
        ov_q <= 1'b1;
      end else if (out_free) begin
        ov_q <= 1'b0;
      end
      if (s2_retire) begin
        parity_q <= parity_d;
        edge_q   <= edge_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Data registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (await_first_q) begin
        qx_q <= query_x_i;
        qy_q <= query_y_i;
        fx_q <= vertex_x_i;
        fy_q <= vertex_y_i;
      end
      px_q     <= vertex_x_i;
      py_q     <= vertex_y_i;
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      bx_q     <= bx_d;
      by_q     <= by_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      first1_q <= await_first_q;
      last1_q  <= last_vertex_i;
    end
    if (s1_move) begin
      p1_axby_q <= p1_axby_d;
      p1_aybx_q <= p1_aybx_d;
      p1_axbx_q <= p1_axbx_d;
      p1_ayby_q <= p1_ayby_d;
      p2_bxcy_q <= p2_bxcy_d;
      p2_bycx_q <= p2_bycx_d;
      p2_bxcx_q <= p2_bxcx_d;
      p2_bycy_q <= p2_bycy_d;
      up1_q     <= (ay_q <= DZero) && (by_q > DZero);
      dn1_q     <= (by_q <= DZero) && (ay_q > DZero);
      up2_q     <= (by_q <= DZero) && (cy_q > DZero);
      dn2_q     <= (cy_q <= DZero) && (by_q > DZero);
      first2_q  <= first1_q;
      last2_q   <= last1_q;
    end
    if (s2_retire && last2_q) begin
      loc_q <= loc_d;
    end
  end

  assign out_valid_o = ov_q;
  assign location_o  = loc_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The last vertex of a polygon re-arms the block for the next one.
  a_last_rearms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_vertex_i |=> await_first_q)
    else $error("last vertex did not re-arm the polygon start");

  // Any other vertex keeps the current polygon open.
  a_mid_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !last_vertex_i |=> !await_first_q)
    else $error("non-final vertex closed the polygon");

  // An item that leaves stage one always lands in stage two.
  a_s1_to_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> v2_q)
    else $error("item lost between stage one and stage two");

  // A new result only comes from a last vertex retiring from stage two.
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(s2_retire && last2_q))
    else $error("result raised without a closing vertex");

endmodule
